// ----- rtl/dstof_pkg.sv -----
// dstof_pkg: shared constants for the two-way ranging time-of-flight block
// no dependencies; imported by every module under rtl

package dstof_pkg;

	// default radio timestamp width used by the datapath
	localparam int STAMP_BITS_DEF = 32;

	// fixed widths of the ports
	localparam int STAMP_IN_BITS = 32;
	localparam int TOF_BITS      = 33;
	localparam int TOF_MAG_BITS  = 32;

	// entries in the queue between the front and the back
	localparam int QUEUE_DEPTH = 4;

	// number of timestamps in one ranging exchange
	localparam int NUM_STAMPS = 6;

	// order of the timestamps in the front's stamp array
	localparam int ST_POLL_TX  = 0;
	localparam int ST_RESP_RX  = 1;
	localparam int ST_FINAL_TX = 2;
	localparam int ST_POLL_RX  = 3;
	localparam int ST_RESP_TX  = 4;
	localparam int ST_FINAL_RX = 5;

endpackage

// ----- rtl/ds_twr_time_of_flight.sv -----
// throughput: one word per cycle; the back pipeline is 3 product/difference stages,
// one divider stage per quotient bit and an output register, all moving together
// a held output word freezes the back; the 4-entry queue then absorbs input words
// reset: arst_n clears the queue and every stage valid at once; no other state
// depends on dstof_pkg, dstof_front, dstof_queue, dstof_back

module ds_twr_time_of_flight #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_poll_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_resp_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_final_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_poll_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_resp_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_final_rx,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dstof_pkg::TOF_BITS-1:0] tof_ticks,
	output logic                                  valid_res
);
	import dstof_pkg::*;

	localparam int QW = 5 * STAMP_BITS + 3;

	logic [QW-1:0] front_word, q_word;
	logic          q_full, q_nonempty, q_pop;

	assign in_stall = q_full;

	dstof_front #(
		.STAMP_BITS(STAMP_BITS)
	) u_front (
		.init_poll_tx (init_poll_tx),
		.init_resp_rx (init_resp_rx),
		.init_final_tx(init_final_tx),
		.resp_poll_rx (resp_poll_rx),
		.resp_resp_tx (resp_resp_tx),
		.resp_final_rx(resp_final_rx),
		.word         (front_word)
	);

	dstof_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_word(front_word),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.pop_word (q_word)
	);

	dstof_back #(
		.STAMP_BITS(STAMP_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(q_nonempty),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tof_ticks (tof_ticks),
		.valid_res (valid_res)
	);

endmodule

// ----- rtl/dstof_front.sv -----
// dstof_front: reduces the six timestamps to the four reply/round intervals
// and their sum, packs them into one queue word; depends on dstof_pkg

module dstof_front #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF
) (
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] init_poll_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] init_resp_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] init_final_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] resp_poll_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] resp_resp_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0] resp_final_rx,
	output logic [5*STAMP_BITS+2:0]            word
);
	import dstof_pkg::*;

	localparam int SB = STAMP_BITS;
	localparam int EW = STAMP_BITS + STAMP_IN_BITS;

	logic [STAMP_IN_BITS-1:0] stamp_raw [NUM_STAMPS];
	logic [SB-1:0]            stamp [NUM_STAMPS];
	logic [SB-1:0]            ra, rb, da, db;
	logic [SB+1:0]            sum;
	logic                     zero;

	assign stamp_raw[ST_POLL_TX]  = init_poll_tx;
	assign stamp_raw[ST_RESP_RX]  = init_resp_rx;
	assign stamp_raw[ST_FINAL_TX] = init_final_tx;
	assign stamp_raw[ST_POLL_RX]  = resp_poll_rx;
	assign stamp_raw[ST_RESP_TX]  = resp_resp_tx;
	assign stamp_raw[ST_FINAL_RX] = resp_final_rx;

	// fit each timestamp to the counter width: zero-extend or drop high bits
	always_comb begin
		logic [EW-1:0] ext;
		for (int i = 0; i < NUM_STAMPS; i++) begin
			ext      = EW'(stamp_raw[i]);
			stamp[i] = ext[SB-1:0];
		end
	end

	// intervals wrap modulo the counter width
	always_comb begin
		ra   = stamp[ST_RESP_RX]  - stamp[ST_POLL_TX];
		rb   = stamp[ST_FINAL_RX] - stamp[ST_RESP_TX];
		da   = stamp[ST_FINAL_TX] - stamp[ST_RESP_RX];
		db   = stamp[ST_RESP_TX]  - stamp[ST_POLL_RX];
		sum  = {2'b00, ra} + {2'b00, rb} + {2'b00, da} + {2'b00, db};
		zero = (sum == '0);
		word = {zero, sum, db, da, rb, ra};
	end

endmodule

// ----- rtl/dstof_queue.sv -----
// dstof_queue: small register fifo between the front and the back
// depends on dstof_pkg for its default depth

module dstof_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dstof_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_word,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] pop_word
);
	import dstof_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ----- rtl/dstof_back.sv -----
// dstof_back: products, signed difference, pipelined restoring divide and
// output register with saturation; depends on dstof_pkg

module dstof_back #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_nonempty,
	input  logic [5*STAMP_BITS+2:0]            q_word,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dstof_pkg::TOF_BITS-1:0] tof_ticks,
	output logic                                valid_res
);
	import dstof_pkg::*;

	localparam int SB = STAMP_BITS;
	localparam int LO = (STAMP_BITS + 1) / 2;
	localparam int HI = STAMP_BITS - LO;
	localparam int PW = 2 * STAMP_BITS;
	localparam int RW = STAMP_BITS + 2;
	localparam int XW = STAMP_BITS + TOF_MAG_BITS;

	logic adv;

	// whole pipeline holds while the output word waits
	assign adv   = !out_valid || !out_stall;
	assign q_pop = adv && q_nonempty;

	// unpack queue word
	logic [SB-1:0] ra, rb, da, db;
	logic [RW-1:0] sum;
	logic          zero;

	assign {zero, sum, db, da, rb, ra} = q_word;

	// stage 1: partial products, halves of 16 bits at the default width
	logic            vld_s1, zero_s1;
	logic [RW-1:0]   sum_s1;
	logic [2*LO-1:0] r_ll_s1, d_ll_s1;
	logic [LO+HI-1:0] r_lh_s1, r_hl_s1, d_lh_s1, d_hl_s1;
	logic [2*HI-1:0] r_hh_s1, d_hh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= zero;
			sum_s1  <= sum;
			r_ll_s1 <= (2*LO)'(ra[LO-1:0]) * (2*LO)'(rb[LO-1:0]);
			r_lh_s1 <= (LO+HI)'(ra[LO-1:0]) * (LO+HI)'(rb[SB-1:LO]);
			r_hl_s1 <= (LO+HI)'(ra[SB-1:LO]) * (LO+HI)'(rb[LO-1:0]);
			r_hh_s1 <= (2*HI)'(ra[SB-1:LO]) * (2*HI)'(rb[SB-1:LO]);
			d_ll_s1 <= (2*LO)'(da[LO-1:0]) * (2*LO)'(db[LO-1:0]);
			d_lh_s1 <= (LO+HI)'(da[LO-1:0]) * (LO+HI)'(db[SB-1:LO]);
			d_hl_s1 <= (LO+HI)'(da[SB-1:LO]) * (LO+HI)'(db[LO-1:0]);
			d_hh_s1 <= (2*HI)'(da[SB-1:LO]) * (2*HI)'(db[SB-1:LO]);
		end
	end

	// stage 2: assemble full products
	logic          vld_s2, zero_s2;
	logic [RW-1:0] sum_s2;
	logic [PW-1:0] pr_s2, pd_s2;
	logic [PW-1:0] pr_c, pd_c;

	always_comb begin
		pr_c = (PW'(r_hh_s1) << (2*LO)) + ((PW'(r_lh_s1) + PW'(r_hl_s1)) << LO)
			+ PW'(r_ll_s1);
		pd_c = (PW'(d_hh_s1) << (2*LO)) + ((PW'(d_lh_s1) + PW'(d_hl_s1)) << LO)
			+ PW'(d_ll_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s2 <= zero_s1;
			sum_s2  <= sum_s1;
			pr_s2   <= pr_c;
			pd_s2   <= pd_c;
		end
	end

	// stage 3: sign and magnitude of the difference
	// quotient is below 2^SB, so the top half of the magnitude is already below the divisor
	logic          vld_s3, zero_s3, neg_s3;
	logic [RW-1:0] sum_s3;
	logic [RW-1:0] rem_s3;
	logic [SB-1:0] nq_s3;
	logic          neg_c;
	logic [PW-1:0] diff_c;

	always_comb begin
		neg_c  = (pr_s2 < pd_s2);
		diff_c = neg_c ? (pd_s2 - pr_s2) : (pr_s2 - pd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3 <= zero_s2;
			neg_s3  <= neg_c;
			sum_s3  <= sum_s2;
			rem_s3  <= {2'b00, diff_c[PW-1:SB]};
			nq_s3   <= diff_c[SB-1:0];
		end
	end

	// stage 4 onward: one quotient bit per stage, quotient shifts in below the dividend
	logic          div_vld_s4  [SB];
	logic          div_zero_s4 [SB];
	logic          div_neg_s4  [SB];
	logic [RW-1:0] div_d_s4    [SB];
	logic [RW-1:0] div_rem_s4  [SB];
	logic [SB-1:0] div_nq_s4   [SB];

	for (genvar k = 0; k < SB; k++) begin : g_div
		logic          vld_in, zero_in, neg_in;
		logic [RW-1:0] d_in, rem_in;
		logic [SB-1:0] nq_in;
		logic [RW:0]   trial, trial_sub;
		logic          take;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s3;
			assign zero_in = zero_s3;
			assign neg_in  = neg_s3;
			assign d_in    = sum_s3;
			assign rem_in  = rem_s3;
			assign nq_in   = nq_s3;
		end else begin : g_next
			assign vld_in  = div_vld_s4[k-1];
			assign zero_in = div_zero_s4[k-1];
			assign neg_in  = div_neg_s4[k-1];
			assign d_in    = div_d_s4[k-1];
			assign rem_in  = div_rem_s4[k-1];
			assign nq_in   = div_nq_s4[k-1];
		end

		always_comb begin
			trial     = {rem_in, nq_in[SB-1]};
			take      = (trial >= {1'b0, d_in});
			trial_sub = trial - {1'b0, d_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s4[k] <= 1'b0;
			end else if (adv) begin
				div_vld_s4[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_zero_s4[k] <= zero_in;
				div_neg_s4[k]  <= neg_in;
				div_d_s4[k]    <= d_in;
				div_rem_s4[k]  <= take ? trial_sub[RW-1:0] : trial[RW-1:0];
				div_nq_s4[k]   <= {nq_in[SB-2:0], take};
			end
		end
	end

	// output register: saturate to 32-bit magnitude, apply sign; zero on a zero divisor
	logic                       out_valid_q, valid_res_q;
	logic signed [TOF_BITS-1:0] tof_q;
	logic [XW-1:0]              quo_ext;
	logic [TOF_MAG_BITS-1:0]    mag;
	logic [TOF_BITS-1:0]        tof_c;

	always_comb begin
		quo_ext = XW'(div_nq_s4[SB-1]);
		mag     = (|quo_ext[XW-1:TOF_MAG_BITS]) ? '1 : quo_ext[TOF_MAG_BITS-1:0];
		if (div_zero_s4[SB-1]) begin
			tof_c = '0;
		end else if (div_neg_s4[SB-1]) begin
			tof_c = TOF_BITS'(0) - {1'b0, mag};
		end else begin
			tof_c = {1'b0, mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_vld_s4[SB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tof_q       <= tof_c;
			valid_res_q <= !div_zero_s4[SB-1];
		end
	end

	assign out_valid = out_valid_q;
	assign tof_ticks = tof_q;
	assign valid_res = valid_res_q;

endmodule

// ----- rtl/dstof_checker.sv -----
// dstof_checker: port-level assertions for ds_twr_time_of_flight, bound below
// depends on dstof_pkg

module dstof_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [dstof_pkg::TOF_BITS-1:0] tof_ticks,
	input logic                                  valid_res
);
	import dstof_pkg::*;

	// no output word on the edge after reset is seen low
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output word valid during reset");

	// zero divisor always reports zero time of flight
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (tof_ticks == '0))
		else $error("nonzero tof with zero divisor");

	// magnitude saturates at 2^32-1, so the most negative code never shows
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tof_ticks != {1'b1, {TOF_MAG_BITS{1'b0}}}))
		else $error("tof magnitude beyond saturation limit");

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(tof_ticks) && $stable(valid_res)))
		else $error("output word changed while stalled");

endmodule

bind ds_twr_time_of_flight dstof_checker u_dstof_checker (.*);

// ----- test/tof_checker.sv -----
`timescale 1ns / 100ps
// tof_checker: watches both channels of ds_twr_time_of_flight, predicts each
// time-of-flight word from the accepted stamps and compares it; needs dstof_pkg

module tof_checker #(
	parameter int STAMP_BITS = dstof_pkg::STAMP_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_poll_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_resp_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   init_final_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_poll_rx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_resp_tx,
	input  logic [dstof_pkg::STAMP_IN_BITS-1:0]   resp_final_rx,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [dstof_pkg::TOF_BITS-1:0] tof_ticks,
	input  logic                                  valid_res,
	output int unsigned                           pending,
	output int unsigned                           mismatches
);

	localparam int PROD_BITS = 2 * STAMP_BITS;
	localparam int PRINT_CAP = 100;

	typedef logic [dstof_pkg::STAMP_IN_BITS-1:0] stamp_t;

	typedef struct packed {
		logic signed [dstof_pkg::TOF_BITS-1:0] tof;
		logic                                  ok;
	} tof_word_t;

	tof_word_t tof_expected [$];

	initial begin
		pending    = 0;
		mismatches = 0;
	end

	function automatic tof_word_t predict_tof(input stamp_t poll_tx, resp_rx, final_tx,
			poll_rx, resp_tx, final_rx);
		logic [STAMP_BITS-1:0]               ra, rb, da, db;
		logic [STAMP_BITS+1:0]               span;
		logic [PROD_BITS-1:0]                round_prod, reply_prod, num, quo;
		logic [dstof_pkg::TOF_MAG_BITS-1:0] mag;
		logic                                neg;
		tof_word_t                           w;
		// intervals wrap at the stamp width
		ra = STAMP_BITS'(resp_rx) - STAMP_BITS'(poll_tx);
		rb = STAMP_BITS'(final_rx) - STAMP_BITS'(resp_tx);
		da = STAMP_BITS'(final_tx) - STAMP_BITS'(resp_rx);
		db = STAMP_BITS'(resp_tx) - STAMP_BITS'(poll_rx);
		span = ra + rb + da + db;
		if (span == '0) begin
			w.tof = '0;
			w.ok  = 1'b0;
			return w;
		end
		round_prod = ra * rb;
		reply_prod = da * db;
		neg = reply_prod > round_prod;
		num = neg ? reply_prod - round_prod : round_prod - reply_prod;
		quo = num / span;
		if ((quo >> dstof_pkg::TOF_MAG_BITS) != '0)
			mag = '1;
		else
			mag = quo[dstof_pkg::TOF_MAG_BITS-1:0];
		w.tof = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		w.ok  = 1'b1;
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		tof_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (tof_expected.size() == 0) begin
					report_mismatch($sformatf("word with nothing expected: tof=%0d valid_res=%b",
						tof_ticks, valid_res));
				end else begin
					want = tof_expected.pop_front();
					if (tof_ticks !== want.tof)
						report_mismatch($sformatf("tof_ticks %0d, expected %0d",
							tof_ticks, want.tof));
					if (valid_res !== want.ok)
						report_mismatch($sformatf("valid_res %b, expected %b",
							valid_res, want.ok));
				end
			end
			if (in_valid && !in_stall)
				tof_expected.push_back(predict_tof(init_poll_tx, init_resp_rx, init_final_tx,
					resp_poll_rx, resp_resp_tx, resp_final_rx));
		end
		pending <= tof_expected.size();
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives ranging exchanges into ds_twr_time_of_flight with random gaps
// and output stalls; checking is done by tof_checker; needs dstof_pkg

module tb_top;

	import dstof_pkg::*;

	localparam int ITEMS        = 1700;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 48;

	typedef logic [STAMP_IN_BITS-1:0] stamp_t;

	typedef struct packed {
		stamp_t poll_tx, resp_rx, final_tx, poll_rx, resp_tx, final_rx;
	} exchange_t;

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        in_valid      = 1'b0;
	logic                        in_stall;
	stamp_t                      init_poll_tx  = '0;
	stamp_t                      init_resp_rx  = '0;
	stamp_t                      init_final_tx = '0;
	stamp_t                      resp_poll_rx  = '0;
	stamp_t                      resp_resp_tx  = '0;
	stamp_t                      resp_final_rx = '0;
	logic                        out_valid;
	logic                        out_stall     = 1'b0;
	logic signed [TOF_BITS-1:0]  tof_ticks;
	logic                        valid_res;
	int unsigned                 pending;
	int unsigned                 mismatches;
	int unsigned                 cycle_count   = 0;
	bit                          gaps_on       = 1'b1;

	ds_twr_time_of_flight u_top (.*);

	tof_checker u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic stamp_t pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(0, 100000);
		if (r < 90) return $urandom_range(0, 32'h00FF_FFFF);
		return $urandom();
	endfunction

	function automatic stamp_t pick_flight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 3000);
		if (r < 95) return $urandom_range(0, 1 << 20);
		return $urandom();
	endfunction

	function automatic stamp_t corner_interval();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 1;
			2: return '1;
			3: return 32'h8000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic exchange_t random_stamps();
		return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// lay the four intervals onto two free-running device clocks
	function automatic exchange_t from_intervals(input stamp_t bi, br, ra, rb, da, db);
		exchange_t x;
		x.poll_tx  = bi;
		x.resp_rx  = bi + ra;
		x.final_tx = bi + ra + da;
		x.poll_rx  = br;
		x.resp_tx  = br + db;
		x.final_rx = br + db + rb;
		return x;
	endfunction

	// a real exchange: round trips are reply delay plus twice the flight, with jitter
	function automatic exchange_t ranging_exchange(input stamp_t flight, da, db, int jitter);
		stamp_t ja, jb;
		ja = stamp_t'($urandom_range(0, 2 * jitter)) - stamp_t'(jitter);
		jb = stamp_t'($urandom_range(0, 2 * jitter)) - stamp_t'(jitter);
		return from_intervals($urandom(), $urandom(), db + 2 * flight + ja,
			da + 2 * flight + jb, da, db);
	endfunction

	task automatic put_fields(input exchange_t x);
		init_poll_tx  <= x.poll_tx;
		init_resp_rx  <= x.resp_rx;
		init_final_tx <= x.final_tx;
		resp_poll_rx  <= x.poll_rx;
		resp_resp_tx  <= x.resp_tx;
		resp_final_rx <= x.final_rx;
	endtask

	task automatic send_exchange(input exchange_t x);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		put_fields(x);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			// idle with junk on the bus
			@(negedge clk);
			in_valid <= 1'b0;
			put_fields(random_stamps());
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	initial begin
		int len;
		forever begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 8);
			@(negedge clk) out_stall <= 1'b0;
			repeat (len - 1) @(negedge clk);
			len = pick_gap();
			if (len > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (len - 1) @(negedge clk);
			end
		end
	end

	initial begin
		exchange_t x;
		int        kind;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// zero divisor: both stamp triples flat
		send_exchange('0);
		send_exchange('1);
		send_exchange(from_intervals('1, '0, 0, 0, 0, 0));
		send_exchange(from_intervals(32'h1234_5678, '1, 0, 0, 0, 0));
		// zero flight, one tick, wrapped stamps
		send_exchange(from_intervals(1000, 5000, 300, 200, 200, 300));
		send_exchange(from_intervals(0, 0, 2, 2, 0, 0));
		send_exchange(from_intervals(32'hFFFF_FFF0, 32'hFFFF_FF00, 1200, 1200, 1000, 1000));
		// largest magnitudes both ways
		send_exchange(from_intervals(1, 1, '1, '1, 0, 0));
		send_exchange(from_intervals(1, 1, 0, 0, '1, '1));
		send_exchange(from_intervals('1, '1, '1, '1, '1, '1));
		send_exchange(from_intervals(7, 9, '1, 1, 0, 0));
		send_exchange(from_intervals(7, 9, '1, 0, 0, 0));
		// truncation toward zero on both signs
		send_exchange(from_intervals(0, 0, 1, 1, 0, 0));
		send_exchange(from_intervals(0, 0, 0, 0, 1, 1));
		send_exchange(from_intervals(0, 0, 3, 3, 0, 0));
		send_exchange(from_intervals(0, 0, 0, 0, 3, 3));
		// reply delays dominate
		send_exchange(from_intervals(500, 900, 100000, 120000, 120010, 100010));
		send_exchange({6{32'hAAAA_AAAA}} ^ {3{64'h0000_0000_FFFF_FFFF}});

		for (int i = 0; i < ITEMS; i++) begin
			if (i % 200 == 0)
				gaps_on = ($urandom_range(0, 9) > 2);
			if (i == ITEMS / 2) begin
				@(negedge clk) in_valid <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 99);
			if (kind < 60)
				x = ranging_exchange(pick_flight(), pick_delay(), pick_delay(),
					$urandom_range(0, 40));
			else if (kind < 75)
				x = random_stamps();
			else if (kind < 85)
				x = from_intervals($urandom(), $urandom(), corner_interval(),
					corner_interval(), corner_interval(), corner_interval());
			else if (kind < 92)
				x = from_intervals($urandom(), $urandom(), 0, 0, 0, 0);
			else
				x = ranging_exchange($urandom_range(0, 3), pick_delay(), pick_delay(), 200);
			send_exchange(x);
		end
		@(negedge clk) in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
